/* hdl/lgrm_pkg.sv */
// Shared types and constants for the LRU group residency manager.
package lgrm_pkg;

    localparam int OP_W    = 3;
    localparam int GRP_W   = 4;
    localparam int CNT_W   = 5;
    localparam int TALLY_W = 16;
    localparam int RES_W   = 2;
    localparam int EVK_W   = 4;
    localparam int MAXR_W  = 5;

    localparam logic [OP_W-1:0] OP_REGISTER = 3'd0;
    localparam logic [OP_W-1:0] OP_LOAD     = 3'd1;
    localparam logic [OP_W-1:0] OP_UNLOAD   = 3'd2;
    localparam logic [OP_W-1:0] OP_PREFETCH = 3'd3;
    localparam logic [OP_W-1:0] OP_TICK     = 3'd4;

    localparam logic [RES_W-1:0] RES_UNLOADED = 2'd0;
    localparam logic [RES_W-1:0] RES_LOADING  = 2'd1;
    localparam logic [RES_W-1:0] RES_RESIDENT = 2'd2;

    localparam logic [CNT_W-1:0] CNT_MAX   = 5'd31;
    localparam logic [EVK_W-1:0] EVICT_CAP = 4'd15;

    typedef struct packed {
        logic lat;
        logic rd;
        logic exec;
        logic scan_clr;
        logic scan;
        logic evict;
        logic fin;
    } t_cmd;

    typedef struct packed {
        logic load_miss;
        logic loop_go;
        logic scan_last;
        logic best_vld;
    } t_sts;

endpackage

/* hdl/lgrm_ram.sv */
// Generic simple dual-port RAM with registered read.
module lgrm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/lgrm_ctrl.sv */
// Sequencing state machine for the residency manager.
module lgrm_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  lgrm_pkg::t_sts i_sts,
    output lgrm_pkg::t_cmd o_cmd,
    output logic          o_busy
);
    import lgrm_pkg::*;

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_RD    = 3'd1;
    localparam logic [2:0] S_EXEC  = 3'd2;
    localparam logic [2:0] S_LOOP  = 3'd3;
    localparam logic [2:0] S_SCAN  = 3'd4;
    localparam logic [2:0] S_TAIL  = 3'd5;
    localparam logic [2:0] S_EVICT = 3'd6;
    localparam logic [2:0] S_FIN   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.lat = 1'b1;
                    n_state   = S_RD;
                end
            end
            S_RD: begin
                o_cmd.rd = 1'b1;
                n_state  = S_EXEC;
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.load_miss ? S_LOOP : S_IDLE;
            end
            S_LOOP: begin
                if (i_sts.loop_go) begin
                    o_cmd.scan_clr = 1'b1;
                    n_state        = S_SCAN;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.scan_last) begin
                    n_state = S_TAIL;
                end
            end
            S_TAIL: begin
                n_state = S_EVICT;
            end
            S_EVICT: begin
                if (i_sts.best_vld) begin
                    o_cmd.evict = 1'b1;
                    n_state     = S_LOOP;
                end else begin
                    n_state = S_FIN;
                end
            end
            S_FIN: begin
                o_cmd.fin = 1'b1;
                n_state   = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

/* hdl/lgrm_dp.sv */
// Group table, counters, victim scan and result register.
module lgrm_dp #(
    parameter int GROUP_COUNT = 16,
    parameter int STAMP_BITS  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  lgrm_pkg::t_cmd                i_cmd,
    output lgrm_pkg::t_sts                o_sts,
    input  logic [lgrm_pkg::MAXR_W-1:0]   i_max,
    input  logic                          i_pf_en,
    input  logic [lgrm_pkg::OP_W-1:0]     i_op,
    input  logic [lgrm_pkg::GRP_W-1:0]    i_group,
    output logic                          o_done,
    output logic                          o_ok,
    output logic                          o_evicted,
    output logic [lgrm_pkg::GRP_W-1:0]    o_evicted_group,
    output logic [lgrm_pkg::RES_W-1:0]    o_group_state,
    output logic [lgrm_pkg::CNT_W-1:0]    o_resident_now,
    output logic [lgrm_pkg::TALLY_W-1:0]  o_loads_done,
    output logic                          o_last
);
    import lgrm_pkg::*;

    localparam int IDXW = $clog2(GROUP_COUNT);
    localparam int LCW  = $clog2(GROUP_COUNT + 1);
    localparam int RW   = ((LCW > CNT_W) ? LCW : CNT_W) + 1;
    localparam int EXW  = GRP_W + IDXW;
    localparam logic [IDXW-1:0] IDX_LAST = IDXW'(GROUP_COUNT - 1);

    // table and counters
    logic [GROUP_COUNT-1:0] r_ex, n_ex;
    logic [GROUP_COUNT-1:0] r_used, n_used;
    logic [RES_W-1:0]       r_res [GROUP_COUNT];
    logic [RES_W-1:0]       n_res [GROUP_COUNT];
    logic [STAMP_BITS-1:0]  r_step, n_step;
    logic [CNT_W-1:0]       r_total, n_total;
    logic [LCW-1:0]         r_ldg, n_ldg;
    logic [EVK_W-1:0]       r_evk, n_evk;

    // latched item
    logic [OP_W-1:0]    r_op;
    logic [IDXW-1:0]    r_gidx;
    logic               r_gval;
    logic [TALLY_W-1:0] r_tally, n_tally;

    // scan
    logic [IDXW-1:0]       r_idx;
    logic                  r_cmp_vld;
    logic [IDXW-1:0]       r_cmp_idx;
    logic                  r_cmp_cand;
    logic                  r_cmp_used;
    logic                  r_best_vld;
    logic [IDXW-1:0]       r_best_idx;
    logic [STAMP_BITS-1:0] r_best_stamp;

    // result register
    logic               r_done, n_done;
    logic               r_ok, n_ok;
    logic               r_ev, n_ev;
    logic [GRP_W-1:0]   r_evg, n_evg;
    logic [RES_W-1:0]   r_gst, n_gst;
    logic [CNT_W-1:0]   r_rnow, n_rnow;
    logic [TALLY_W-1:0] r_lds, n_lds;
    logic               r_last, n_last;

    // RAM ports
    logic                  stamp_we;
    logic [STAMP_BITS-1:0] stamp_q;
    logic                  tally_we;
    logic [TALLY_W-1:0]    tally_wdata;
    logic [TALLY_W-1:0]    tally_q;

    logic [EXW-1:0]        grp_ext;
    logic [EXW-1:0]        best_ext;
    logic [RES_W-1:0]      cur_res;
    logic                  known;
    logic [TALLY_W-1:0]    tally_cur;
    logic [TALLY_W-1:0]    tally_inc;
    logic [RW-1:0]         occ;
    logic [STAMP_BITS-1:0] stamp_eff;

    assign grp_ext   = {{IDXW{1'b0}}, i_group};
    assign best_ext  = {{GRP_W{1'b0}}, r_best_idx};
    assign cur_res   = r_res[r_gidx];
    assign known     = r_gval && r_ex[r_gidx];
    assign tally_cur = r_used[r_gidx] ? tally_q : '0;
    assign tally_inc = (r_tally != '1) ? r_tally + 1'b1 : r_tally;
    assign occ       = RW'(r_total) + RW'(r_ldg);
    assign stamp_eff = r_cmp_used ? stamp_q : '0;

    assign o_sts.load_miss = (r_op == OP_LOAD) && known
                             && (cur_res != RES_RESIDENT) && (cur_res != RES_LOADING);
    assign o_sts.loop_go   = (i_max != '0) && (r_total >= CNT_W'(i_max))
                             && (r_evk < EVICT_CAP);
    assign o_sts.scan_last = (r_idx == IDX_LAST);
    assign o_sts.best_vld  = r_best_vld;

    always_comb begin
        n_ex        = r_ex;
        n_used      = r_used;
        n_res       = r_res;
        n_step      = r_step;
        n_total     = r_total;
        n_ldg       = r_ldg;
        n_evk       = r_evk;
        n_tally     = r_tally;
        n_done      = 1'b0;
        n_ok        = r_ok;
        n_ev        = r_ev;
        n_evg       = r_evg;
        n_gst       = r_gst;
        n_rnow      = r_rnow;
        n_lds       = r_lds;
        n_last      = r_last;
        stamp_we    = 1'b0;
        tally_we    = 1'b0;
        tally_wdata = tally_inc;

        if (i_cmd.exec) begin
            n_tally = tally_cur;
            n_evk   = '0;
            n_done  = 1'b1;
            n_ok    = 1'b0;
            n_ev    = 1'b0;
            n_evg   = '0;
            n_gst   = '0;
            n_lds   = '0;
            n_last  = 1'b1;
            if (r_op == OP_TICK) begin
                if (r_step != '1) begin
                    n_step = r_step + 1'b1;
                end
                n_ok = 1'b1;
            end else if (r_op > OP_TICK || !r_gval) begin
                n_ok = 1'b0;
            end else if (r_op == OP_REGISTER) begin
                n_ex[r_gidx] = 1'b1;
                if (i_max == '0) begin
                    n_res[r_gidx] = RES_RESIDENT;
                    if (cur_res == RES_LOADING) begin
                        n_ldg = r_ldg - 1'b1;
                    end
                end
                n_ok  = 1'b1;
                n_gst = n_res[r_gidx];
                n_lds = tally_cur;
            end else if (!known) begin
                n_gst = cur_res;
                n_lds = tally_cur;
            end else begin
                n_ok  = 1'b1;
                n_lds = tally_cur;
                case (r_op)
                    OP_LOAD: begin
                        stamp_we       = 1'b1;
                        n_used[r_gidx] = 1'b1;
                        if (cur_res == RES_LOADING) begin
                            n_res[r_gidx] = RES_RESIDENT;
                            n_ldg         = r_ldg - 1'b1;
                            if (r_total != CNT_MAX) begin
                                n_total = r_total + 1'b1;
                            end
                            tally_we    = 1'b1;
                            tally_wdata = (tally_cur != '1) ? tally_cur + 1'b1 : tally_cur;
                            n_tally     = tally_wdata;
                            n_lds       = tally_wdata;
                        end else if (cur_res != RES_RESIDENT) begin
                            n_done = 1'b0;
                        end
                    end
                    OP_UNLOAD: begin
                        if (cur_res != RES_UNLOADED) begin
                            n_res[r_gidx] = RES_UNLOADED;
                            if (r_total != '0) begin
                                n_total = r_total - 1'b1;
                            end
                            if (cur_res == RES_LOADING) begin
                                n_ldg = r_ldg - 1'b1;
                            end
                        end
                    end
                    OP_PREFETCH: begin
                        if (i_pf_en && cur_res == RES_UNLOADED
                            && (i_max == '0 || occ < RW'(i_max))) begin
                            n_res[r_gidx] = RES_LOADING;
                            n_ldg         = r_ldg + 1'b1;
                        end
                    end
                    default: begin
                        n_ok = 1'b1;
                    end
                endcase
                n_gst = n_res[r_gidx];
            end
            n_rnow = n_total;
        end

        if (i_cmd.evict) begin
            n_res[r_best_idx] = RES_UNLOADED;
            if (r_total != '0) begin
                n_total = r_total - 1'b1;
            end
            n_evk  = r_evk + 1'b1;
            n_done = 1'b1;
            n_ok   = 1'b1;
            n_ev   = 1'b1;
            n_evg  = best_ext[GRP_W-1:0];
            n_gst  = cur_res;
            n_rnow = n_total;
            n_lds  = r_tally;
            n_last = 1'b0;
        end

        if (i_cmd.fin) begin
            n_res[r_gidx] = RES_RESIDENT;
            if (r_total != CNT_MAX) begin
                n_total = r_total + 1'b1;
            end
            tally_we    = 1'b1;
            tally_wdata = tally_inc;
            n_tally     = tally_inc;
            n_done      = 1'b1;
            n_ok        = 1'b1;
            n_ev        = 1'b0;
            n_evg       = '0;
            n_gst       = RES_RESIDENT;
            n_rnow      = n_total;
            n_lds       = tally_inc;
            n_last      = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ex    <= '0;
            r_used  <= '0;
            r_step  <= '0;
            r_total <= '0;
            r_ldg   <= '0;
            r_evk   <= '0;
            r_done  <= 1'b0;
            for (int i = 0; i < GROUP_COUNT; i++) begin
                r_res[i] <= RES_UNLOADED;
            end
        end else begin
            r_ex    <= n_ex;
            r_used  <= n_used;
            r_res   <= n_res;
            r_step  <= n_step;
            r_total <= n_total;
            r_ldg   <= n_ldg;
            r_evk   <= n_evk;
            r_done  <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_tally <= n_tally;
        r_ok    <= n_ok;
        r_ev    <= n_ev;
        r_evg   <= n_evg;
        r_gst   <= n_gst;
        r_rnow  <= n_rnow;
        r_lds   <= n_lds;
        r_last  <= n_last;
        if (i_cmd.lat) begin
            r_op   <= i_op;
            r_gidx <= grp_ext[IDXW-1:0];
            r_gval <= (grp_ext < EXW'(GROUP_COUNT));
        end
    end

    // victim scan: issue one entry a cycle, compare it in the cycle after its issue
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp_vld  <= 1'b0;
            r_best_vld <= 1'b0;
            r_idx      <= '0;
        end else begin
            r_cmp_vld <= i_cmd.scan;
            if (i_cmd.scan_clr) begin
                r_idx      <= '0;
                r_best_vld <= 1'b0;
            end else begin
                if (i_cmd.scan) begin
                    r_idx <= r_idx + 1'b1;
                end
                if (r_cmp_vld && r_cmp_cand && (!r_best_vld || stamp_eff < r_best_stamp)) begin
                    r_best_vld <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmp_idx  <= r_idx;
        r_cmp_cand <= r_ex[r_idx] && (r_res[r_idx] == RES_RESIDENT) && (r_idx != r_gidx);
        r_cmp_used <= r_used[r_idx];
        if (r_cmp_vld && r_cmp_cand && (!r_best_vld || stamp_eff < r_best_stamp)) begin
            r_best_idx   <= r_cmp_idx;
            r_best_stamp <= stamp_eff;
        end
    end

    lgrm_ram #(
        .WIDTH(STAMP_BITS),
        .DEPTH(GROUP_COUNT)
    ) u_stamp_ram (
        .i_clk  (i_clk),
        .i_we   (stamp_we),
        .i_waddr(r_gidx),
        .i_wdata(r_step),
        .i_re   (i_cmd.scan),
        .i_raddr(r_idx),
        .o_rdata(stamp_q)
    );

    lgrm_ram #(
        .WIDTH(TALLY_W),
        .DEPTH(GROUP_COUNT)
    ) u_tally_ram (
        .i_clk  (i_clk),
        .i_we   (tally_we),
        .i_waddr(r_gidx),
        .i_wdata(tally_wdata),
        .i_re   (i_cmd.rd),
        .i_raddr(r_gidx),
        .o_rdata(tally_q)
    );

    assign o_done          = r_done;
    assign o_ok            = r_ok;
    assign o_evicted       = r_ev;
    assign o_evicted_group = r_evg;
    assign o_group_state   = r_gst;
    assign o_resident_now  = r_rnow;
    assign o_loads_done    = r_lds;
    assign o_last          = r_last;

endmodule

/* hdl/lru_group_residency_manager_core.sv */
// Top level of the LRU group residency manager with its register port.
//
//  channel   handshake                         payload
//  request   start & !busy                     i_op, i_group
//  result    o_done (one-cycle strobe)         o_ok, o_evicted, o_evicted_group,
//                                              o_group_state, o_resident_now,
//                                              o_loads_done, o_last
//  config    psel & penable & pwrite & pready  paddr, pwdata (prdata on read)
//
// A request other than a load of a registered, unloaded group passes S_RD and S_EXEC
// after accept and has its result registered from S_EXEC; busy is high in between.
// A load of a registered, unloaded group passes S_RD and S_EXEC, then runs a victim scan
// over all entries (S_LOOP, S_SCAN, S_TAIL, S_EVICT) per eviction, plus a scan when the
// last one finds no victim, and ends in S_FIN; the scan reads the stamp RAM one entry per cycle.
// Reset is synchronous and clears the group table state bits and the step, resident, loading and eviction counters.
// Results are never held off: each one is shown for exactly one cycle.
module lru_group_residency_manager_core #(
    parameter int GROUP_COUNT = 16,
    parameter int STAMP_BITS  = 32
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [lgrm_pkg::OP_W-1:0]     i_op,
    input  logic [lgrm_pkg::GRP_W-1:0]    i_group,
    output logic                          o_done,
    output logic                          o_ok,
    output logic                          o_evicted,
    output logic [lgrm_pkg::GRP_W-1:0]    o_evicted_group,
    output logic [lgrm_pkg::RES_W-1:0]    o_group_state,
    output logic [lgrm_pkg::CNT_W-1:0]    o_resident_now,
    output logic [lgrm_pkg::TALLY_W-1:0]  o_loads_done,
    output logic                          o_last,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [2:0]                    paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);
    import lgrm_pkg::*;

    localparam logic REG_MAX_RESIDENT = 1'b0;
    localparam logic REG_PREFETCH_EN  = 1'b1;

    logic [MAXR_W-1:0] r_max;
    logic              r_pf_en;
    t_cmd              cmd;
    t_sts              sts;
    logic              wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max   <= '0;
            r_pf_en <= 1'b0;
        end else if (wr_en) begin
            case (paddr[2])
                REG_MAX_RESIDENT: r_max   <= pwdata[MAXR_W-1:0];
                REG_PREFETCH_EN:  r_pf_en <= pwdata[0];
                default: begin
                    r_pf_en <= r_pf_en;
                end
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_MAX_RESIDENT: prdata = {{(32-MAXR_W){1'b0}}, r_max};
            REG_PREFETCH_EN:  prdata = {31'd0, r_pf_en};
            default:          prdata = '0;
        endcase
    end

    lgrm_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(start),
        .i_sts  (sts),
        .o_cmd  (cmd),
        .o_busy (busy)
    );

    lgrm_dp #(
        .GROUP_COUNT(GROUP_COUNT),
        .STAMP_BITS (STAMP_BITS)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .o_sts          (sts),
        .i_max          (r_max),
        .i_pf_en        (r_pf_en),
        .i_op           (i_op),
        .i_group        (i_group),
        .o_done         (o_done),
        .o_ok           (o_ok),
        .o_evicted      (o_evicted),
        .o_evicted_group(o_evicted_group),
        .o_group_state  (o_group_state),
        .o_resident_now (o_resident_now),
        .o_loads_done   (o_loads_done),
        .o_last         (o_last)
    );

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for the LRU group residency manager core.
`timescale 1ns / 1ps

module testbench;
    import lgrm_pkg::*;

    localparam int GROUP_COUNT = 16;
    localparam int STAMP_BITS  = 32;

    localparam logic [2:0] ADDR_MAX_RESIDENT = 3'd0;
    localparam logic [2:0] ADDR_PREFETCH_EN  = 3'd4;

    typedef struct packed {
        logic                 ok;
        logic                 evicted;
        logic [GRP_W-1:0]     evicted_group;
        logic [RES_W-1:0]     group_state;
        logic [CNT_W-1:0]     resident_now;
        logic [TALLY_W-1:0]   loads_done;
        logic                 last;
    } residency_result_t;

    class residency_scoreboard;
        logic [MAXR_W-1:0]     limit;
        logic                  prefetch_on;
        logic                  exists_q[GROUP_COUNT];
        logic [RES_W-1:0]      state_q[GROUP_COUNT];
        logic [STAMP_BITS-1:0] stamp_q[GROUP_COUNT];
        logic [TALLY_W-1:0]    tally_q[GROUP_COUNT];
        logic [STAMP_BITS-1:0] step_count;
        logic [CNT_W-1:0]      resident_count;
        residency_result_t     expected_results[$];
        int                    mismatches;

        function new();
            limit = '0;
            prefetch_on = 1'b0;
            for (int i = 0; i < GROUP_COUNT; i++) begin
                exists_q[i] = 1'b0;
                state_q[i]  = RES_UNLOADED;
                stamp_q[i]  = '0;
                tally_q[i]  = '0;
            end
            step_count = '0;
            resident_count = '0;
            mismatches = 0;
        endfunction

        task report(input string msg);
            $display("mismatch @%0t: %s", $realtime, msg);
            mismatches++;
        endtask

        function void set_reg(input logic [2:0] addr, input logic [31:0] data);
            if (addr == ADDR_MAX_RESIDENT) limit = data[MAXR_W-1:0];
            else if (addr == ADDR_PREFETCH_EN) prefetch_on = data[0];
        endfunction

        function logic [31:0] reg_value(input logic [2:0] addr);
            if (addr == ADDR_MAX_RESIDENT) return 32'(limit);
            return 32'(prefetch_on);
        endfunction

        function int pending();
            return expected_results.size();
        endfunction

        function void push_result(input logic ok, input logic ev, input logic [GRP_W-1:0] evg,
                                  input logic [RES_W-1:0] gs, input logic [TALLY_W-1:0] ld,
                                  input logic last);
            residency_result_t r;
            r.ok = ok;
            r.evicted = ev;
            r.evicted_group = evg;
            r.group_state = gs;
            r.resident_now = resident_count;
            r.loads_done = ld;
            r.last = last;
            expected_results.insert(expected_results.size(), r);
        endfunction

        function void count_up();
            if (resident_count < CNT_MAX) resident_count++;
        endfunction

        function void count_down();
            if (resident_count != '0) resident_count--;
        endfunction

        function int lru_victim(input logic [GRP_W-1:0] skip);
            int best;
            logic [STAMP_BITS-1:0] best_stamp;
            best = -1;
            best_stamp = '0;
            for (int i = 0; i < GROUP_COUNT; i++) begin
                if (i != skip && exists_q[i] && state_q[i] == RES_RESIDENT &&
                    (best < 0 || stamp_q[i] < best_stamp)) begin
                    best = i;
                    best_stamp = stamp_q[i];
                end
            end
            return best;
        endfunction

        function void note_request(input logic [OP_W-1:0] op, input logic [GRP_W-1:0] g);
            int evictions;
            int victim;
            int loading;
            bit room;
            evictions = 0;
            if (op == OP_TICK) begin
                if (step_count != '1) step_count++;
                push_result(1'b1, 1'b0, '0, RES_UNLOADED, '0, 1'b1);
                return;
            end
            if (op > OP_TICK) begin
                push_result(1'b0, 1'b0, '0, RES_UNLOADED, '0, 1'b1);
                return;
            end
            if (op == OP_REGISTER) begin
                exists_q[g] = 1'b1;
                if (limit == '0) state_q[g] = RES_RESIDENT;
                push_result(1'b1, 1'b0, '0, state_q[g], tally_q[g], 1'b1);
                return;
            end
            if (!exists_q[g]) begin
                push_result(1'b0, 1'b0, '0, state_q[g], tally_q[g], 1'b1);
                return;
            end
            if (op == OP_LOAD) begin
                stamp_q[g] = step_count;
                if (state_q[g] == RES_LOADING) begin
                    state_q[g] = RES_RESIDENT;
                    count_up();
                    if (tally_q[g] != '1) tally_q[g]++;
                end else if (state_q[g] != RES_RESIDENT) begin
                    if (limit != '0) begin
                        victim = 0;
                        while (resident_count >= limit && evictions < EVICT_CAP && victim >= 0) begin
                            victim = lru_victim(g);
                            if (victim >= 0) begin
                                state_q[victim] = RES_UNLOADED;
                                count_down();
                                push_result(1'b1, 1'b1, victim[GRP_W-1:0], state_q[g],
                                            tally_q[g], 1'b0);
                                evictions++;
                            end
                        end
                    end
                    state_q[g] = RES_RESIDENT;
                    count_up();
                    if (tally_q[g] != '1) tally_q[g]++;
                end
            end else if (op == OP_UNLOAD) begin
                if (state_q[g] != RES_UNLOADED) begin
                    state_q[g] = RES_UNLOADED;
                    count_down();
                end
            end else if (prefetch_on && state_q[g] == RES_UNLOADED) begin
                room = 1'b1;
                if (limit != '0) begin
                    loading = 0;
                    for (int i = 0; i < GROUP_COUNT; i++)
                        if (exists_q[i] && state_q[i] == RES_LOADING) loading++;
                    room = (int'(resident_count) + loading) < int'(limit);
                end
                if (room) state_q[g] = RES_LOADING;
            end
            push_result(1'b1, 1'b0, '0, state_q[g], tally_q[g], 1'b1);
        endfunction

        task check_result(input residency_result_t got);
            residency_result_t exp;
            if (expected_results.size() == 0) begin
                report($sformatf("unexpected result ok=%0d ev=%0d evg=%0d st=%0d res=%0d ld=%0d last=%0d",
                       got.ok, got.evicted, got.evicted_group, got.group_state,
                       got.resident_now, got.loads_done, got.last));
                return;
            end
            exp = expected_results.pop_front();
            if (got !== exp)
                report($sformatf("exp ok=%0d ev=%0d evg=%0d st=%0d res=%0d ld=%0d last=%0d | got ok=%0d ev=%0d evg=%0d st=%0d res=%0d ld=%0d last=%0d",
                       exp.ok, exp.evicted, exp.evicted_group, exp.group_state,
                       exp.resident_now, exp.loads_done, exp.last,
                       got.ok, got.evicted, got.evicted_group, got.group_state,
                       got.resident_now, got.loads_done, got.last));
        endtask
    endclass

    logic                i_clk;
    logic                i_rst_n = 1'b0;
    logic                start   = 1'b0;
    logic                busy;
    logic [OP_W-1:0]     i_op    = '0;
    logic [GRP_W-1:0]    i_group = '0;
    logic                o_done;
    logic                o_ok;
    logic                o_evicted;
    logic [GRP_W-1:0]    o_evicted_group;
    logic [RES_W-1:0]    o_group_state;
    logic [CNT_W-1:0]    o_resident_now;
    logic [TALLY_W-1:0]  o_loads_done;
    logic                o_last;
    logic                psel    = 1'b0;
    logic                penable = 1'b0;
    logic                pwrite  = 1'b0;
    logic [2:0]          paddr   = '0;
    logic [31:0]         pwdata  = '0;
    logic [31:0]         prdata;
    logic                pready;

    residency_scoreboard sb;
    bit                  idle_on;

    lru_group_residency_manager_core #(
        .GROUP_COUNT(GROUP_COUNT),
        .STAMP_BITS(STAMP_BITS)
    ) uut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .start(start),
        .busy(busy),
        .i_op(i_op),
        .i_group(i_group),
        .o_done(o_done),
        .o_ok(o_ok),
        .o_evicted(o_evicted),
        .o_evicted_group(o_evicted_group),
        .o_group_state(o_group_state),
        .o_resident_now(o_resident_now),
        .o_loads_done(o_loads_done),
        .o_last(o_last),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result({o_ok, o_evicted, o_evicted_group, o_group_state,
                             o_resident_now, o_loads_done, o_last});
    end

    task automatic issue(input logic [OP_W-1:0] op, input logic [GRP_W-1:0] g);
        int n;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            n = $urandom_range(1, 7);
            start <= 1'b0;
            repeat (n) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_op    <= op;
        i_group <= g;
        do @(posedge i_clk); while (busy);
        sb.note_request(op, g);
    endtask

    task automatic drain();
        start <= 1'b0;
        while (sb.pending() != 0 || busy) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic reg_access(input logic [2:0] addr, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_reg(addr, data);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== sb.reg_value(addr))
            sb.report($sformatf("register %0d read %0h, exp %0h", addr, prdata,
                      sb.reg_value(addr)));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input int max_res, input int pf);
        drain();
        reg_access(ADDR_MAX_RESIDENT, 32'(max_res));
        reg_access(ADDR_PREFETCH_EN, 32'(pf));
    endtask

    function automatic logic [OP_W-1:0] pick_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return OP_REGISTER;
        if (r < 47) return OP_LOAD;
        if (r < 62) return OP_UNLOAD;
        if (r < 77) return OP_PREFETCH;
        if (r < 95) return OP_TICK;
        return OP_TICK + OP_W'($urandom_range(1, 3));
    endfunction

    // fill the table at a limit of 16, then tighten it and load the last group
    task automatic squeeze_table(input int tight_limit);
        int order[GROUP_COUNT];
        int j;
        int t;
        for (int i = 0; i < GROUP_COUNT; i++) order[i] = i;
        for (int i = GROUP_COUNT - 1; i > 0; i--) begin
            j = $urandom_range(0, i);
            t = order[i];
            order[i] = order[j];
            order[j] = t;
        end
        configure(16, $urandom_range(0, 1));
        for (int i = 0; i < GROUP_COUNT; i++) issue(OP_UNLOAD, GRP_W'(order[i]));
        for (int i = 0; i < GROUP_COUNT; i++) issue(OP_REGISTER, GRP_W'(order[i]));
        for (int i = 0; i < GROUP_COUNT - 1; i++) begin
            if ($urandom_range(0, 2) == 0) issue(OP_TICK, GRP_W'($urandom));
            issue(OP_LOAD, GRP_W'(order[i]));
        end
        configure(tight_limit, $urandom_range(0, 1));
        issue(OP_LOAD, GRP_W'(order[GROUP_COUNT - 1]));
    endtask

    task automatic random_phase(input int max_res, input int count);
        int base;
        int span;
        configure(max_res, $urandom_range(0, 1));
        base = $urandom_range(0, GROUP_COUNT - 1);
        span = $urandom_range(3, GROUP_COUNT);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 9) == 0)
                issue(pick_op(), GRP_W'($urandom));
            else
                issue(pick_op(), GRP_W'((base + $urandom_range(0, span - 1)) % GROUP_COUNT));
        end
    endtask

    initial begin
        sb = new();
        idle_on = 1'b1;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        configure(0, 0);
        issue(OP_TICK, 4'hF);
        issue(OP_LOAD, 4'd5);
        issue(OP_UNLOAD, 4'd5);
        issue(OP_PREFETCH, 4'd5);
        for (int o = OP_TICK + 1; o < 8; o++) issue(o[OP_W-1:0], 4'hF);
        issue(OP_REGISTER, 4'd0);
        issue(OP_REGISTER, 4'hF);
        issue(OP_UNLOAD, 4'd0);
        issue(OP_LOAD, 4'hF);
        issue(OP_LOAD, 4'd0);
        issue(OP_PREFETCH, 4'hF);

        configure(16, 1);
        issue(OP_REGISTER, 4'd1);
        issue(OP_PREFETCH, 4'd1);
        issue(OP_LOAD, 4'd1);
        issue(OP_REGISTER, 4'd2);
        issue(OP_TICK, 4'd0);
        issue(OP_LOAD, 4'd2);

        configure(2, 1);
        issue(OP_REGISTER, 4'd3);
        issue(OP_LOAD, 4'd3);
        issue(OP_REGISTER, 4'd4);
        issue(OP_PREFETCH, 4'd4);
        issue(OP_UNLOAD, 4'd3);
        issue(OP_LOAD, 4'd0);

        squeeze_table(1);
        random_phase(0, 40);
        random_phase(16, 40);
        random_phase(1, 40);
        squeeze_table($urandom_range(1, 3));
        random_phase(4, 40);
        random_phase($urandom_range(0, 16), 40);
        idle_on = 1'b0;
        random_phase(2, 40);

        drain();
        repeat (16) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

    initial begin
        #(10_000_000);
        $display("testbench: FAIL");
        $finish;
    end

endmodule
